FILE: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// shared constants, types and the witness table of the prime check core
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int NUM_WIT   = 12;
  localparam int WIT_IDX_W = 4;
  localparam int WIT_W     = 6;
  localparam int DEG_W     = 17;
  localparam int DIV_W     = DEG_W + 1;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(1024);

  // register index taken from the word address
  localparam logic REG_RING_DEGREE = 1'b0;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SHIFT  = 10'b00_0000_0010,
    S_WIT    = 10'b00_0000_0100,
    S_PSTEP  = 10'b00_0000_1000,
    S_PMUL_W = 10'b00_0001_0000,
    S_PSQ_W  = 10'b00_0010_0000,
    S_CHECK  = 10'b00_0100_0000,
    S_LOOP   = 10'b00_1000_0000,
    S_LOOP_W = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } pfc_state_t;

  function automatic logic [WIT_W-1:0] witness_val(input logic [WIT_IDX_W-1:0] idx);
    logic [WIT_W-1:0] v;
    case (idx)
      4'd0:    v = 6'd2;
      4'd1:    v = 6'd3;
      4'd2:    v = 6'd5;
      4'd3:    v = 6'd7;
      4'd4:    v = 6'd11;
      4'd5:    v = 6'd13;
      4'd6:    v = 6'd17;
      4'd7:    v = 6'd19;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd29;
      4'd10:   v = 6'd31;
      4'd11:   v = 6'd37;
      default: v = 6'd2;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/pfc_mulmod.sv
// ----------------------------------------------------------------------------
// pfc_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pfc_mulmod #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] prod
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] a_r, a_nxt, b_r, b_nxt, m_r, m_nxt, acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [WIDTH+1:0] sum;
  logic [WIDTH+2:0] d1, d2;
  logic [WIDTH-1:0] step_val;

  // acc, a < m so 2*acc + a < 3m: reduce by m or 2m
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + {2'b00, (b_r[WIDTH-1] ? a_r : '0)};
    d1  = {1'b0, sum} - {3'b000, m_r};
    d2  = {1'b0, sum} - {2'b00, m_r, 1'b0};
    if (!d2[WIDTH+2]) begin
      step_val = d2[WIDTH-1:0];
    end else if (!d1[WIDTH+2]) begin
      step_val = d1[WIDTH-1:0];
    end else begin
      step_val = sum[WIDTH-1:0];
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      m_nxt    = modulus;
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = step_val;
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: hdl/pfc_rem.sv
// ----------------------------------------------------------------------------
// pfc_rem
// restoring remainder of the candidate by twice the ring degree
// ----------------------------------------------------------------------------
module pfc_rem
  import pfc_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W+1:0] diff;

  always_comb begin
    trial    = {rem_r, q_r[WIDTH-1]};
    diff     = {1'b0, trial} - {2'b00, divisor};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = diff[DIV_W+1] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
      q_nxt   = {q_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

FILE: hdl/ntt_friendly_prime_check_core.sv
// ----------------------------------------------------------------------------
// ntt_friendly_prime_check_core
// deterministic miller-rabin test of one candidate per item, with a check
// that the candidate is 1 modulo twice the ring degree
// ----------------------------------------------------------------------------
//  channel  | ports                                    | moves
//  ---------+------------------------------------------+--------------------------
//  input    | in_valid, in_ready, in_candidate_modulus | one candidate per item
//  result   | out_valid, out_ready, out_*_flag         | prime and friendly flags
//  config   | cfg_psel ... cfg_pready (apb style)      | ring_degree at address 0
//
//  the time one item takes is set by the single bit-serial modular
//  multiplier that every exponentiation and squaring goes through;
//  small and even candidates finish once the remainder unit is done
//  in_ready is high only in the idle state; a finished item waits in the
//  output register, and a new item is taken while it waits
//  rst_n is synchronous; ring_degree resets to 1024
// ----------------------------------------------------------------------------
module ntt_friendly_prime_check_core
  import pfc_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_candidate_modulus,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_prime_flag,
  output logic              out_ntt_friendly_flag,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(WIDTH);

  pfc_state_t       state_r, state_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;       // candidate
  logic [WIDTH-1:0] d_r, d_nxt;       // odd part of n-1
  logic [CNT_W-1:0] r_r, r_nxt;       // power of two in n-1
  logic [CNT_W-1:0] i_r, i_nxt;       // squarings left
  logic [WIDTH-1:0] e_r, e_nxt;       // exponent bits left
  logic [WIDTH-1:0] res_r, res_nxt;   // running power, then x
  logic [WIDTH-1:0] sq_r, sq_nxt;     // base squared up
  logic [WIT_IDX_W-1:0] wit_r, wit_nxt;
  logic             prime_r, prime_nxt;
  logic [DEG_W-1:0] deg_r, deg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_prime_r, out_prime_nxt;
  logic             out_friendly_r, out_friendly_nxt;

  logic [WIDTH-1:0] cand;
  logic [WIDTH-1:0] n_m1;
  logic [WIDTH-1:0] wit_ext;
  logic             in_fire;
  logic             cfg_wr;

  logic             mm_start, mm_busy, mm_done;
  logic [WIDTH-1:0] mm_a, mm_b, mm_prod;
  logic             rem_busy;
  logic [DIV_W-1:0] rem_val, two_n;

  assign cand     = in_candidate_modulus[WIDTH-1:0];
  assign n_m1     = n_r - 1'b1;
  assign wit_ext  = {{(WIDTH-WIT_W){1'b0}}, witness_val(wit_r)};
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign two_n    = {deg_r, 1'b0};

  // config port, zero wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_RING_DEGREE) ?
                      {{(DATA_W-DEG_W){1'b0}}, deg_r} : '0;
  assign deg_nxt    = (cfg_wr && cfg_paddr[2] == REG_RING_DEGREE) ?
                      cfg_pwdata[DEG_W-1:0] : deg_r;

  pfc_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (n_r),
    .busy    (mm_busy),
    .done    (mm_done),
    .prod    (mm_prod)
  );

  pfc_rem #(.WIDTH(WIDTH)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .dividend (cand),
    .divisor  (two_n),
    .busy     (rem_busy),
    .rem      (rem_val)
  );

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    d_nxt            = d_r;
    r_nxt            = r_r;
    i_nxt            = i_r;
    e_nxt            = e_r;
    res_nxt          = res_r;
    sq_nxt           = sq_r;
    wit_nxt          = wit_r;
    prime_nxt        = prime_r;
    out_prime_nxt    = out_prime_r;
    out_friendly_nxt = out_friendly_r;
    out_valid_nxt    = out_ready ? 1'b0 : out_valid_r;
    mm_start         = 1'b0;
    mm_a             = sq_r;
    mm_b             = sq_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt   = cand;
          d_nxt   = cand - 1'b1;
          r_nxt   = '0;
          wit_nxt = '0;
          if (cand[WIDTH-1:1] == '0) begin
            // zero and one
            prime_nxt = 1'b0;
            state_nxt = S_FIN;
          end else if (cand[WIDTH-1:2] == '0) begin
            // two and three
            prime_nxt = 1'b1;
            state_nxt = S_FIN;
          end else if (!cand[0]) begin
            prime_nxt = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (d_r[0]) begin
          state_nxt = S_WIT;
        end else begin
          d_nxt = {1'b0, d_r[WIDTH-1:1]};
          r_nxt = r_r + 1'b1;
        end
      end
      S_WIT: begin
        if (wit_r == WIT_IDX_W'(NUM_WIT)) begin
          prime_nxt = 1'b1;
          state_nxt = S_FIN;
        end else if (wit_ext >= n_r) begin
          wit_nxt = wit_r + 1'b1;
        end else begin
          res_nxt   = WIDTH'(1);
          sq_nxt    = wit_ext;
          e_nxt     = d_r;
          state_nxt = S_PSTEP;
        end
      end
      S_PSTEP: begin
        if (e_r == '0) begin
          state_nxt = S_CHECK;
        end else if (e_r[0]) begin
          mm_start  = 1'b1;
          mm_a      = res_r;
          state_nxt = S_PMUL_W;
        end else begin
          mm_start  = 1'b1;
          state_nxt = S_PSQ_W;
        end
      end
      S_PMUL_W: begin
        if (mm_done) begin
          res_nxt   = mm_prod;
          mm_start  = 1'b1;
          state_nxt = S_PSQ_W;
        end
      end
      S_PSQ_W: begin
        if (mm_done) begin
          sq_nxt    = mm_prod;
          e_nxt     = {1'b0, e_r[WIDTH-1:1]};
          state_nxt = S_PSTEP;
        end
      end
      S_CHECK: begin
        if (res_r == WIDTH'(1) || res_r == n_m1) begin
          wit_nxt   = wit_r + 1'b1;
          state_nxt = S_WIT;
        end else begin
          i_nxt     = r_r - 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (i_r == '0) begin
          // no square reached n-1: composite
          prime_nxt = 1'b0;
          state_nxt = S_FIN;
        end else begin
          mm_start  = 1'b1;
          mm_a      = res_r;
          mm_b      = res_r;
          i_nxt     = i_r - 1'b1;
          state_nxt = S_LOOP_W;
        end
      end
      S_LOOP_W: begin
        if (mm_done) begin
          res_nxt = mm_prod;
          if (mm_prod == n_m1) begin
            wit_nxt   = wit_r + 1'b1;
            state_nxt = S_WIT;
          end else begin
            state_nxt = S_LOOP;
          end
        end
      end
      S_FIN: begin
        if (!rem_busy && (!out_valid_r || out_ready)) begin
          out_valid_nxt    = 1'b1;
          out_prime_nxt    = prime_r;
          out_friendly_nxt = prime_r && (deg_r != '0) && (rem_val == DIV_W'(1));
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      deg_r       <= DEG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      deg_r       <= deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    d_r            <= d_nxt;
    r_r            <= r_nxt;
    i_r            <= i_nxt;
    e_r            <= e_nxt;
    res_r          <= res_nxt;
    sq_r           <= sq_nxt;
    wit_r          <= wit_nxt;
    prime_r        <= prime_nxt;
    out_prime_r    <= out_prime_nxt;
    out_friendly_r <= out_friendly_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_is_prime_flag     = out_prime_r;
  assign out_ntt_friendly_flag = out_friendly_r;

  // the shared multiplier is never restarted while it runs
  a_mm_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_busy)
    else $error("multiplier restarted while busy");

  // a new candidate is never taken while the multiplier still runs
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mm_busy)
    else $error("idle while multiplier busy");

  // friendliness implies primality
  a_friendly_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ntt_friendly_flag) |-> out_is_prime_flag)
    else $error("friendly flag without prime flag");

  // a new result only ever comes out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && !out_ready)) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish state");

endmodule
